### hdl/cmp_pkg.sv
// Shared constants, types and helpers for the column mean profile block.
package cmp_pkg;

	localparam int SAMPLES  = 1024;
	localparam int MAX_ROWS = 4096;
	localparam int AMP_BITS = 16;

	localparam int IDX_W  = $clog2(SAMPLES);
	localparam int LEN_W  = $clog2(SAMPLES + 1);
	localparam int CNT_W  = $clog2(MAX_ROWS + 1);
	localparam int SUM_W  = AMP_BITS + $clog2(MAX_ROWS + 1);
	localparam int FRAC_W = 8;
	localparam int QUO_W  = SUM_W + FRAC_W;
	localparam int MEAN_W = 24;

	localparam int IN_IDX_W = 10;
	localparam int IN_AMP_W = 16;
	localparam int IN_DATA_W = 32;
	localparam int IN_USER_W = 3;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		K_ACC = 2'd0,
		K_QRY = 2'd1,
		K_CLR = 2'd2,
		K_NOP = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                 kind;
		logic                 side;
		logic [IN_IDX_W-1:0]  idx;
		logic [IN_AMP_W-1:0]  amp;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
	} acc_word_t;

	function automatic logic [MEAN_W-1:0] mean_sat(input logic [QUO_W-1:0] q);
		logic [MEAN_W-1:0] r;
		r = (|q[QUO_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : q[MEAN_W-1:0];
		return r;
	endfunction

endpackage

### hdl/cmp_front.sv
// Front end: request intake, command classification and a short request queue.
module cmp_front
	import cmp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  hold,
	output logic                  q_valid,
	input  logic                  q_ready,
	output item_t                 q_item
);

	item_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	item_t              in_item;
	logic               push;
	logic               pop;

	always_comb begin
		in_item.kind = cmd_t'(s_axis_tuser[1:0]);
		in_item.side = s_axis_tuser[2];
		in_item.idx  = s_axis_tdata[IN_IDX_W-1:0];
		in_item.amp  = s_axis_tdata[IN_IDX_W+IN_AMP_W-1:IN_IDX_W];
	end

	assign s_axis_tready = (cnt_q != QCNT_W'(QDEPTH)) && !hold;
	assign push = s_axis_tvalid && s_axis_tready && (in_item.kind != K_NOP);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/cmp_div.sv
// Shared restoring divider, one quotient bit per cycle.
module cmp_div
	import cmp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QUO_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(QUO_W);

	logic [CNT_W:0]     rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W:0]     trial;
	logic               fits;

	assign trial = {rem_q[CNT_W-1:0], quo_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign done  = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == STEP_W'(QUO_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

### hdl/cmp_back.sv
// Back end: accumulator memories, clear sweep, query sequencing and result register.
module cmp_back
	import cmp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  item_t                  q_item,
	output logic                   hold,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,
	output logic [OUT_USER_W-1:0]  m_axis_tuser
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_DIVP  = 6'b000100,
		ST_DIVS  = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_CLEAR = 6'b100000
	} bk_state_t;

	bk_state_t          state_q;
	item_t              cur_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic               init_q;
	logic [LEN_W-1:0]   len_q;
	logic               go_q;

	acc_word_t          port_mem [SAMPLES];
	acc_word_t          stbd_mem [SAMPLES];
	logic [1:0]         live_mem [SAMPLES];
	acc_word_t          port_rd_q;
	acc_word_t          stbd_rd_q;
	logic [1:0]         live_rd_q;

	logic [MEAN_W-1:0]  pm_q;
	logic [MEAN_W-1:0]  sm_q;
	logic               out_valid_q;
	logic [MEAN_W-1:0]  out_pm_q;
	logic [MEAN_W-1:0]  out_sm_q;
	logic               out_pv_q;
	logic               out_sv_q;
	logic [LEN_W-1:0]   out_len_q;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   cur_idx;
	logic               in_rng;
	logic               acc_go;
	acc_word_t          sel_word;
	logic               sel_live;
	acc_word_t          upd_word;
	logic               upd_wr;
	logic               port_we;
	logic               stbd_we;
	logic               live_we;
	logic [IDX_W-1:0]   live_widx;
	logic [1:0]         live_wdata;
	logic [LEN_W-1:0]   idx_next;
	logic               pv;
	logic               sv;
	logic               div_done;
	logic [QUO_W-1:0]   div_quo;
	logic [QUO_W-1:0]   div_dvd;
	logic [CNT_W-1:0]   div_dvs;
	logic               out_free;

	assign q_ready = (state_q == ST_IDLE);
	assign hold    = init_q;
	assign rd_en   = q_valid && q_ready;
	assign rd_idx  = q_item.idx[IDX_W-1:0];
	assign cur_idx = cur_q.idx[IDX_W-1:0];
	assign in_rng  = (LEN_W'(cur_q.idx) < LEN_W'(SAMPLES));
	assign idx_next = LEN_W'(cur_q.idx) + 1'b1;

	assign sel_word = cur_q.side ? stbd_rd_q : port_rd_q;
	assign sel_live = live_rd_q[cur_q.side];

	always_comb begin
		upd_word = sel_word;
		upd_wr   = 1'b0;
		if (!sel_live) begin
			upd_word.cnt = CNT_W'(1);
			upd_word.sum = SUM_W'(cur_q.amp[AMP_BITS-1:0]);
			upd_wr       = 1'b1;
		end else if (sel_word.cnt < CNT_W'(MAX_ROWS)) begin
			upd_word.cnt = sel_word.cnt + 1'b1;
			upd_word.sum = sel_word.sum + SUM_W'(cur_q.amp[AMP_BITS-1:0]);
			upd_wr       = 1'b1;
		end
	end

	assign acc_go  = (state_q == ST_READ) && (cur_q.kind == K_ACC) && in_rng;
	assign port_we = acc_go && upd_wr && !cur_q.side;
	assign stbd_we = acc_go && upd_wr && cur_q.side;
	assign live_we = acc_go || (state_q == ST_CLEAR);
	assign live_widx = (state_q == ST_CLEAR) ? clr_idx_q : cur_idx;
	assign live_wdata = (state_q == ST_CLEAR) ? 2'b00
		: (live_rd_q | (cur_q.side ? 2'b10 : 2'b01));

	always_ff @(posedge clk) begin
		if (port_we) begin
			port_mem[cur_idx] <= upd_word;
		end
		if (stbd_we) begin
			stbd_mem[cur_idx] <= upd_word;
		end
		if (live_we) begin
			live_mem[live_widx] <= live_wdata;
		end
		if (rd_en) begin
			port_rd_q <= port_mem[rd_idx];
			stbd_rd_q <= stbd_mem[rd_idx];
			live_rd_q <= live_mem[rd_idx];
		end
	end

	assign pv = in_rng && live_rd_q[0] && (port_rd_q.cnt != '0);
	assign sv = in_rng && live_rd_q[1] && (stbd_rd_q.cnt != '0);

	assign div_dvd = (state_q == ST_DIVS) ? {stbd_rd_q.sum, {FRAC_W{1'b0}}}
		: {port_rd_q.sum, {FRAC_W{1'b0}}};
	assign div_dvs = (state_q == ST_DIVS) ? stbd_rd_q.cnt : port_rd_q.cnt;

	cmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_q <= q_item;
		end
		if ((state_q == ST_DIVP) && div_done) begin
			pm_q <= pv ? mean_sat(div_quo) : '0;
		end
		if ((state_q == ST_DIVS) && div_done) begin
			sm_q <= sv ? mean_sat(div_quo) : '0;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_pm_q  <= pm_q;
			out_sm_q  <= sm_q;
			out_pv_q  <= pv;
			out_sv_q  <= sv;
			out_len_q <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			init_q      <= 1'b1;
			len_q       <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= ((state_q == ST_READ) && (cur_q.kind == K_QRY))
				|| ((state_q == ST_DIVP) && div_done);
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rd_en) begin
						if (q_item.kind == K_CLR) begin
							state_q   <= ST_CLEAR;
							clr_idx_q <= '0;
							len_q     <= '0;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (cur_q.kind == K_QRY) begin
						state_q <= ST_DIVP;
					end else begin
						state_q <= ST_IDLE;
						if (acc_go && (idx_next > len_q)) begin
							len_q <= idx_next;
						end
					end
				end
				ST_DIVP: begin
					if (div_done) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(SAMPLES - 1)) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_len_q, out_sm_q, out_pm_q});
	assign m_axis_tuser  = {out_sv_q, out_pv_q};

endmodule

### hdl/column_mean_profile_top.sv
// Top level of the two-sided per-column mean accumulator.
//
// Input stream (s_axis): one request per handshake. tuser carries the command
// (accumulate, query, clear; the fourth code is dropped) and the side; tdata
// carries the sample index and the amplitude. Output stream (m_axis): one
// result per query with both sides' means (16.8), valid flags and the profile
// length.
// A two-entry request queue decouples intake from the back end, and a result
// register holds a finished query while intake continues.
// In the back end an accumulate request does a memory read, then a write;
// a clear sweeps one live-bit entry per cycle; a query runs the
// shared one-bit-per-cycle divider once per side over 37 quotient bits.
// After reset the live bits are swept with s_axis_tready low.
// A stalled receiver holds the result register; the back end then waits in
// its emit step and the queue fills, after which s_axis_tready drops.
module column_mean_profile_top
	import cmp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // sample_index, amplitude, zero pad
	input  logic [IN_USER_W-1:0]   s_axis_tuser,   // cmd, side
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // port mean, starboard mean, profile_length, zero pad
	output logic [OUT_USER_W-1:0]  m_axis_tuser    // port_valid, stbd_valid
);

	logic   hold;
	logic   q_valid;
	logic   q_ready;
	item_t  q_item;

	cmp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.hold          (hold),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item)
	);

	cmp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.hold          (hold),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

### hdl/cmp_chk.sv
// Port-level checker for the column mean profile top level, with its bind.
module cmp_chk
	import cmp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_DATA_W-1:0]   s_axis_tdata,
	input logic [IN_USER_W-1:0]   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [OUT_USER_W-1:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:0] == '0)
		else $error("port mean nonzero without port valid");

	a_stbd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[47:24] == '0)
		else $error("starboard mean nonzero without starboard valid");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[58:48] <= LEN_W'(SAMPLES))
		else $error("profile length beyond sample count");

endmodule

bind column_mean_profile_top cmp_chk u_chk (.*);
